/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* design/mbrf_pkg.sv */
// ----------------------------------------------------------------------------
// mbrf_pkg
// shared types, constants and crc step for the request framer
// ----------------------------------------------------------------------------
package mbrf_pkg;

   localparam logic [2:0]  CMD_WR_COIL    = 3'd4;
   localparam logic [2:0]  CMD_LAST_VALID = 3'd5;

   localparam logic [15:0] COIL_ON_VALUE  = 16'hFF00;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  MBAP_LENGTH    = 8'd6;

   localparam logic [3:0]  RTU_LAST_IDX   = 4'd7;
   localparam logic [3:0]  TCP_LAST_IDX   = 4'd11;
   localparam logic [3:0]  PDU_BYTES      = 4'd6;

   localparam logic        MODE_RTU       = 1'b0;
   localparam logic        MODE_TCP       = 1'b1;

   localparam logic        REG_UNIT_ID    = 1'b0;
   localparam logic        REG_FRAME_MODE = 1'b1;

   // frame handed from the request register to the byte serialiser
   typedef struct packed {
      logic              valid;
      logic              tcp;
      logic [15:0]       tid;
      logic [5:0][7:0]   pdu;
   } frame_type;

   // one byte through the reflected crc-16 polynomial, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* design/modbus_request_framer.sv */
// ----------------------------------------------------------------------------
// modbus_request_framer
// builds modbus rtu or tcp request frames and sends them one byte a transfer
// ----------------------------------------------------------------------------
// a request passes through the request register and then the frame register before
//   the first byte of its frame is shown; the byte serialiser sends one byte per cycle
//   while rsp_tready is high, an rtu frame is 8 bytes and a tcp frame 12, no gaps
// one request can wait in the request register while a frame is being sent
// reset: synchronous, clears handshake state and the transaction number,
//   unit id returns to 1 and framing to rtu

module modbus_request_framer (
   input  logic        clock,
   input  logic        reset,

   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] command, [18:3] start_address,
                                    // [34:19] quantity_or_value, [39:35] zero

   // frame byte stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // frame_last

   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]          unit_id_reg_ff;
   logic                frame_mode_ff;
   logic                csr_write;
   logic                take;
   mbrf_pkg::frame_type frame;

   // ---------------------------------------------------------------- registers
   // register index is the word address; a write lands on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_reg_ff <= 8'd1;
         frame_mode_ff  <= mbrf_pkg::MODE_RTU;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            mbrf_pkg::REG_UNIT_ID:    unit_id_reg_ff <= csr_pwdata[7:0];
            mbrf_pkg::REG_FRAME_MODE: frame_mode_ff  <= csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mbrf_pkg::REG_UNIT_ID:    csr_prdata = {24'h000000, unit_id_reg_ff};
         mbrf_pkg::REG_FRAME_MODE: csr_prdata = {31'h00000000, frame_mode_ff};
      endcase
   end

   // ---------------------------------------------------------- request stage
   // assembles the pdu, drops unknown commands, numbers tcp transfers
   mbrf_builder u_builder (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .command           (req_tdata[2:0]),
      .start_address     (req_tdata[18:3]),
      .quantity_or_value (req_tdata[34:19]),
      .unit_id           (unit_id_reg_ff),
      .frame_mode        (frame_mode_ff),
      .take              (take),
      .frame             (frame)
   );

   // ------------------------------------------------------------- serialiser
   // walks the frame one byte per transfer and folds the crc in as it goes
   mbrf_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_byte   (rsp_tdata),
      .frame_last (rsp_tlast)
   );

endmodule

/* design/mbrf_builder.sv */
// ----------------------------------------------------------------------------
// mbrf_builder
// request register: pdu assembly and transaction numbering
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbrf_builder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          command,
   input  logic [15:0]         start_address,
   input  logic [15:0]         quantity_or_value,
   input  logic [7:0]          unit_id,
   input  logic                frame_mode,
   input  logic                take,
   output mbrf_pkg::frame_type frame
);

   logic              hold_valid_ff, hold_valid_in;
   logic              tcp_ff;
   logic [15:0]       tid_ff, tid_in;
   logic [15:0]       frame_tid_ff;
   logic [5:0][7:0]   pdu_ff;
   logic [5:0][7:0]   pdu_in;
   logic [15:0]       value;
   logic              accept;
   logic              cmd_ok;
   logic              acc_tcp;

   assign req_tready = !hold_valid_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign cmd_ok     = (command <= mbrf_pkg::CMD_LAST_VALID);
   assign acc_tcp    = accept && cmd_ok && (frame_mode == mbrf_pkg::MODE_TCP);

   always_comb begin
      if (command == mbrf_pkg::CMD_WR_COIL) begin
         value = (quantity_or_value != 16'h0000) ? mbrf_pkg::COIL_ON_VALUE : 16'h0000;
      end else begin
         value = quantity_or_value;
      end
      pdu_in[0] = unit_id;
      pdu_in[1] = {5'b00000, command} + 8'd1;
      pdu_in[2] = start_address[15:8];
      pdu_in[3] = start_address[7:0];
      pdu_in[4] = value[15:8];
      pdu_in[5] = value[7:0];
   end

   // unknown commands are swallowed here and never reach the serialiser
   assign hold_valid_in = (hold_valid_ff && !take) || (accept && cmd_ok);
   assign tid_in        = acc_tcp ? tid_ff + 16'd1 : tid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         tid_ff        <= 16'h0000;
      end else begin
         hold_valid_ff <= hold_valid_in;
         tid_ff        <= tid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cmd_ok) begin
         pdu_ff       <= pdu_in;
         tcp_ff       <= (frame_mode == mbrf_pkg::MODE_TCP);
         frame_tid_ff <= tid_ff;
      end
   end

   assign frame.valid = hold_valid_ff;
   assign frame.tcp   = tcp_ff;
   assign frame.tid   = frame_tid_ff;
   assign frame.pdu   = pdu_ff;

   // a stalled request stays in the register until the serialiser takes it
   `ASSERT_CLK(a_hold_kept, clock, reset, (hold_valid_ff && !take) |=> hold_valid_ff)
   // the transaction number only moves on an accepted tcp request
   `ASSERT_CLK(a_tid_step, clock, reset, (!$past(reset) && !$stable(tid_ff)) |-> $past(acc_tcp))

endmodule

/* design/mbrf_serializer.sv */
// ----------------------------------------------------------------------------
// mbrf_serializer
// frame register and byte serialiser with running crc
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbrf_serializer (
   input  logic                clock,
   input  logic                reset,
   input  mbrf_pkg::frame_type frame,
   output logic                take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          out_byte,
   output logic                frame_last
);

   logic              busy_ff, busy_in;
   logic [3:0]        idx_ff, idx_in;
   logic [15:0]       crc_ff, crc_in;
   logic              tcp_ff;
   logic [15:0]       tid_ff;
   logic [5:0][7:0]   pdu_ff;
   logic              load;
   logic              xfer;
   logic [3:0]        last_idx;
   logic [2:0]        pdu_sel;

   assign last_idx   = tcp_ff ? mbrf_pkg::TCP_LAST_IDX : mbrf_pkg::RTU_LAST_IDX;
   assign frame_last = (idx_ff == last_idx);
   assign rsp_tvalid = busy_ff;
   assign xfer       = busy_ff && rsp_tready;
   assign take       = !busy_ff || (xfer && frame_last);
   assign load       = take && frame.valid;

   // byte select: pdu first in rtu, mbap header first in tcp
   always_comb begin
      if (tcp_ff) begin
         pdu_sel = 3'(idx_ff - mbrf_pkg::PDU_BYTES);
      end else begin
         pdu_sel = idx_ff[2:0];
      end
      out_byte = 8'h00;
      if (tcp_ff) begin
         if (idx_ff == 4'd0) begin
            out_byte = tid_ff[15:8];
         end else if (idx_ff == 4'd1) begin
            out_byte = tid_ff[7:0];
         end else if (idx_ff == 4'd5) begin
            out_byte = mbrf_pkg::MBAP_LENGTH;
         end else if (idx_ff >= mbrf_pkg::PDU_BYTES && idx_ff <= mbrf_pkg::TCP_LAST_IDX) begin
            out_byte = pdu_ff[pdu_sel];
         end
      end else begin
         if (idx_ff < mbrf_pkg::PDU_BYTES) begin
            out_byte = pdu_ff[pdu_sel];
         end else if (idx_ff == mbrf_pkg::PDU_BYTES) begin
            out_byte = crc_ff[7:0];
         end else if (idx_ff == mbrf_pkg::RTU_LAST_IDX) begin
            out_byte = crc_ff[15:8];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
         crc_in  = mbrf_pkg::CRC_INIT;
      end else if (xfer) begin
         if (frame_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
         // in rtu mode the crc runs over the pdu bytes as they leave
         if (!tcp_ff && idx_ff < mbrf_pkg::PDU_BYTES) begin
            crc_in = mbrf_pkg::crc_byte(crc_ff, out_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (load) begin
         tcp_ff <= frame.tcp;
         tid_ff <= frame.tid;
         pdu_ff <= frame.pdu;
      end
   end

   // the byte index never runs past the end of the current frame
   `ASSERT_NEVER(a_idx_range, clock, reset, busy_ff && (idx_ff > last_idx))
   // after the last byte leaves with nothing waiting the serialiser goes idle
   `ASSERT_CLK(a_drain_idle, clock, reset, (xfer && frame_last && !frame.valid) |=> !busy_ff)

endmodule
